FILE: rtl/asl_pkg.sv
// ============================================================================
// asl_pkg
// Shared constants, keyword table and character helpers for the source lexer.
// ============================================================================
package asl_pkg;

  localparam int MAX_TOKEN = 32;
  localparam int AW        = $clog2(MAX_TOKEN);
  localparam int LW        = $clog2(MAX_TOKEN + 1);
  localparam int NUM_KW    = 39;
  localparam logic [5:0] NO_KW = 6'd39;

  // scan modes
  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_IGNORE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // token kinds
  localparam logic [3:0] KIND_OP       = 4'd0;
  localparam logic [3:0] KIND_REG      = 4'd1;
  localparam logic [3:0] KIND_TRP      = 4'd2;
  localparam logic [3:0] KIND_PSEUDO   = 4'd3;
  localparam logic [3:0] KIND_LBL      = 4'd4;
  localparam logic [3:0] KIND_IMM      = 4'd5;
  localparam logic [3:0] KIND_STR      = 4'd6;
  localparam logic [3:0] KIND_BAD      = 4'd7;
  localparam logic [3:0] KIND_TOO_LONG = 4'd8;

  // numeric base of the first character
  localparam logic [1:0] BASE_NONE = 2'd0;
  localparam logic [1:0] BASE_DEC  = 2'd1;
  localparam logic [1:0] BASE_BIN  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // keyword text, right aligned, and length
  localparam logic [63:0] KW_TXT [NUM_KW] = '{
    "ADD", "AND", "BR", "BRN", "BRZ", "BRP", "JMP", "JSR", "JSRR", "LD",
    "LDI", "LDR", "LEA", "NOT", "RET", "RTI", "ST", "STI", "STR", "TRAP",
    "R0", "R1", "R2", "R3", "R4", "R5", "R6", "R7",
    "GETC", "OUT", "PUTS", "IN", "PUTSP", "HALT",
    ".ORIG", ".END", ".BLKW", ".FILL", ".STRINGZ"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd2,
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd4,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
    4'd4, 4'd3, 4'd4, 4'd2, 4'd5, 4'd4,
    4'd5, 4'd4, 4'd5, 4'd5, 4'd8
  };

  // character i of keyword k, zero past its end
  function automatic logic [7:0] kw_char(input int k, input logic [LW-1:0] i);
    logic [3:0] l;
    logic [2:0] p;
    l = KW_LEN[k];
    p = 3'(l - 4'd1 - 4'(i[2:0]));
    if ((i >= LW'(8)) || ({1'b0, i[2:0]} >= l))
      return 8'h00;
    return KW_TXT[k][{p, 3'b000} +: 8];
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_COMMA);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
  endfunction

endpackage

FILE: rtl/asl_ram.sv
// ============================================================================
// asl_ram
// Generic single-port-write, registered-read RAM.
// ============================================================================
module asl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/assembly_source_lexer.sv
// A byte that ends no token leaves the input ready for the next byte.
// A finished token of n characters gives n results, each a buffer read (S_RD)
// then presentation (S_OUT); an empty token or too_long result goes straight to presentation.
// No new byte is taken until the last result of a token has been accepted.
// Reset (rst_n low, synchronous) returns to searching mode, line 0, no error.
// After a too_long result the block drops all input until reset.
// ============================================================================
// assembly_source_lexer
// Byte-serial lexer: tracks token class while characters arrive, then walks
// the token buffer to emit one character per output request.
// ============================================================================
module assembly_source_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_char
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] token_char, [13:8] keyword_index,
                                  // [29:14] line_number, [31:30] zero
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_char
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam int AW = asl_pkg::AW;
  localparam int LW = asl_pkg::LW;
  localparam int NK = asl_pkg::NUM_KW;

  // scan state
  logic [1:0]    mode_r, mode_nxt;
  logic          instr_r, instr_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [15:0]   line_r, line_nxt;
  logic [15:0]   tline_r, tline_nxt;
  logic          stuck_r, stuck_nxt;
  logic [NK-1:0] alive_r, alive_nxt;
  logic [1:0]    base_r, base_nxt;
  logic          more_r, more_nxt;
  logic          bad_r, bad_nxt;
  logic          colon_r, colon_nxt;
  logic [LW-1:0] cpos_r, cpos_nxt;

  // emission state
  logic [1:0]    st_r, st_nxt;
  logic [LW-1:0] eidx_r, eidx_nxt;
  logic [LW-1:0] ecnt_r, ecnt_nxt;
  logic [3:0]    ekind_r, ekind_nxt;
  logic [5:0]    ekw_r, ekw_nxt;
  logic          eup_r, eup_nxt;
  logic          ezero_r, ezero_nxt;
  logic [15:0]   eline_r, eline_nxt;

  logic          acc;
  logic [7:0]    b, ub;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;
  logic          fin, ovf, app, to_ignore;
  logic          numeric;
  logic [5:0]    kw_hit;
  logic [LW-1:0] lab_len, run_len;
  logic [7:0]    ochar;

  assign acc = in_tvalid && in_tready;
  assign b   = in_tdata;
  assign ub  = asl_pkg::to_upper(b);

  // token buffer
  asl_ram #(.WIDTH(8), .DEPTH(asl_pkg::MAX_TOKEN)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (b),
    .rd_addr (eidx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // per-byte scan and token tracking
  always_comb begin
    mode_nxt  = mode_r;
    instr_nxt = instr_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    tline_nxt = tline_r;
    stuck_nxt = stuck_r;
    alive_nxt = alive_r;
    base_nxt  = base_r;
    more_nxt  = more_r;
    bad_nxt   = bad_r;
    colon_nxt = colon_r;
    cpos_nxt  = cpos_r;
    wr_en     = 1'b0;
    wr_addr   = len_r[AW-1:0];
    fin       = 1'b0;
    ovf       = 1'b0;
    app       = 1'b0;
    to_ignore = 1'b0;
    if (acc && !stuck_r) begin
      unique case (mode_r)
        asl_pkg::MODE_IGNORE: begin
          if (b == asl_pkg::CH_NL) begin
            mode_nxt = asl_pkg::MODE_SEARCH;
            if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
          end
        end
        asl_pkg::MODE_READ: begin
          if (instr_r) begin
            if (b == asl_pkg::CH_QUOTE) begin
              fin = 1'b1;
            end else begin
              if (b == asl_pkg::CH_NL && line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
              app = 1'b1;
            end
          end else if (asl_pkg::is_sep(b)) begin
            if (b == asl_pkg::CH_NL && line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
            fin = 1'b1;
          end else if (b == asl_pkg::CH_SEMI) begin
            fin       = 1'b1;
            to_ignore = 1'b1;
          end else if (b != asl_pkg::CH_QUOTE) begin
            app = 1'b1;
          end
        end
        default: begin
          if (b == asl_pkg::CH_NL) begin
            if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
          end else if (b == asl_pkg::CH_SEMI) begin
            mode_nxt = asl_pkg::MODE_IGNORE;
          end else if (!asl_pkg::is_sep(b)) begin
            tline_nxt = line_r;
            mode_nxt  = asl_pkg::MODE_READ;
            len_nxt   = '0;
            colon_nxt = 1'b0;
            bad_nxt   = 1'b0;
            if (b == asl_pkg::CH_QUOTE) begin
              instr_nxt = 1'b1;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              len_nxt   = LW'(1);
              colon_nxt = (b == asl_pkg::CH_COLON);
              cpos_nxt  = '0;
              more_nxt  = 1'b1;
              if (asl_pkg::is_dig(b)) begin
                base_nxt = asl_pkg::BASE_DEC;
                more_nxt = 1'b0;
              end else if (b == asl_pkg::CH_HASH || b == asl_pkg::CH_MINUS) begin
                base_nxt = asl_pkg::BASE_DEC;
              end else if (b == "b" || b == "B") begin
                base_nxt = asl_pkg::BASE_BIN;
              end else if (b == "x" || b == "X") begin
                base_nxt = asl_pkg::BASE_HEX;
              end else begin
                base_nxt = asl_pkg::BASE_NONE;
              end
              for (int k = 0; k < NK; k++) begin
                alive_nxt[k] = (asl_pkg::kw_char(k, '0) == ub);
              end
            end
          end
        end
      endcase

      // append one character at the current length
      if (app) begin
        if (len_r >= LW'(asl_pkg::MAX_TOKEN)) begin
          ovf       = 1'b1;
          stuck_nxt = 1'b1;
        end else begin
          wr_en   = 1'b1;
          len_nxt = len_r + LW'(1);
          if (!colon_r && b == asl_pkg::CH_COLON) begin
            colon_nxt = 1'b1;
            cpos_nxt  = len_r;
          end
          if (b == asl_pkg::CH_MINUS) begin
            if (len_r > LW'(1)) bad_nxt = 1'b1;
          end else begin
            unique case (base_r)
              asl_pkg::BASE_DEC: if (!asl_pkg::is_dig(b)) bad_nxt = 1'b1;
              asl_pkg::BASE_BIN: if (b != "0" && b != "1") bad_nxt = 1'b1;
              asl_pkg::BASE_HEX: if (!asl_pkg::is_hexd(b)) bad_nxt = 1'b1;
              default: ;
            endcase
          end
          for (int k = 0; k < NK; k++) begin
            alive_nxt[k] = alive_r[k] && (asl_pkg::kw_char(k, len_r) == ub);
          end
        end
      end

      // end of text finishes a pending token and restarts the scan
      if (!ovf && in_tlast) begin
        if (mode_nxt == asl_pkg::MODE_READ && !fin) fin = 1'b1;
      end
    end
  end

  // classification of the token as it stands after this byte
  always_comb begin
    kw_hit = asl_pkg::NO_KW;
    for (int k = NK - 1; k >= 0; k--) begin
      if (alive_nxt[k] && (LW'(asl_pkg::KW_LEN[k]) == len_nxt)) kw_hit = 6'(k);
    end
  end
  assign numeric = (base_nxt != asl_pkg::BASE_NONE) && (!more_nxt || len_nxt > LW'(1));
  assign lab_len = colon_nxt ? cpos_nxt : len_nxt;

  // emission sequencer
  always_comb begin
    st_nxt    = st_r;
    eidx_nxt  = eidx_r;
    ecnt_nxt  = ecnt_r;
    ekind_nxt = ekind_r;
    ekw_nxt   = ekw_r;
    eup_nxt   = eup_r;
    ezero_nxt = ezero_r;
    eline_nxt = eline_r;
    run_len   = len_nxt;
    unique case (st_r)
      S_IDLE: begin
        if (ovf) begin
          ekind_nxt = asl_pkg::KIND_TOO_LONG;
          ekw_nxt   = asl_pkg::NO_KW;
          ezero_nxt = 1'b1;
          eline_nxt = tline_r;
          st_nxt    = S_OUT;
        end else if (fin) begin
          ekw_nxt   = asl_pkg::NO_KW;
          eup_nxt   = 1'b0;
          eline_nxt = tline_nxt;
          if (instr_nxt || len_nxt == '0) begin
            ekind_nxt = asl_pkg::KIND_STR;
          end else if (numeric && !bad_nxt) begin
            ekind_nxt = asl_pkg::KIND_IMM;
          end else if (kw_hit != asl_pkg::NO_KW) begin
            ekw_nxt = kw_hit;
            eup_nxt = 1'b1;
            if (kw_hit < 6'd20)      ekind_nxt = asl_pkg::KIND_OP;
            else if (kw_hit < 6'd28) ekind_nxt = asl_pkg::KIND_REG;
            else if (kw_hit < 6'd34) ekind_nxt = asl_pkg::KIND_TRP;
            else                     ekind_nxt = asl_pkg::KIND_PSEUDO;
          end else if (numeric) begin
            ekind_nxt = asl_pkg::KIND_BAD;
          end else begin
            ekind_nxt = asl_pkg::KIND_LBL;
            eup_nxt   = 1'b1;
            run_len   = lab_len;
          end
          ecnt_nxt  = run_len;
          eidx_nxt  = '0;
          ezero_nxt = (run_len == '0);
          st_nxt    = (run_len == '0) ? S_OUT : S_RD;
        end
      end
      S_RD: st_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) begin
          if (ezero_r || (eidx_r + LW'(1) == ecnt_r)) begin
            st_nxt = S_IDLE;
          end else begin
            eidx_nxt = eidx_r + LW'(1);
            st_nxt   = S_RD;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= asl_pkg::MODE_SEARCH;
      instr_r <= 1'b0;
      len_r   <= '0;
      line_r  <= '0;
      tline_r <= '0;
      stuck_r <= 1'b0;
      st_r    <= S_IDLE;
    end else begin
      stuck_r <= stuck_nxt;
      tline_r <= tline_nxt;
      st_r    <= st_nxt;
      if (acc && !stuck_r && !ovf && in_tlast) begin
        mode_r  <= asl_pkg::MODE_SEARCH;
        instr_r <= 1'b0;
        len_r   <= '0;
        line_r  <= '0;
      end else if (fin) begin
        mode_r  <= to_ignore ? asl_pkg::MODE_IGNORE : asl_pkg::MODE_SEARCH;
        instr_r <= 1'b0;
        len_r   <= '0;
        line_r  <= line_nxt;
      end else begin
        mode_r  <= mode_nxt;
        instr_r <= instr_nxt;
        len_r   <= len_nxt;
        line_r  <= line_nxt;
      end
    end
  end

  // tracking and emission payload
  always_ff @(posedge clk) begin
    alive_r <= alive_nxt;
    base_r  <= base_nxt;
    more_r  <= more_nxt;
    bad_r   <= bad_nxt;
    colon_r <= colon_nxt;
    cpos_r  <= cpos_nxt;
    eidx_r  <= eidx_nxt;
    ecnt_r  <= ecnt_nxt;
    ekind_r <= ekind_nxt;
    ekw_r   <= ekw_nxt;
    eup_r   <= eup_nxt;
    ezero_r <= ezero_nxt;
    eline_r <= eline_nxt;
  end

  // output port
  assign ochar      = ezero_r ? 8'h00 : (eup_r ? asl_pkg::to_upper(rd_data) : rd_data);
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {2'b00, eline_r, ekw_r, ochar};
  assign out_tuser  = ekind_r;
  assign out_tlast  = ezero_r || (eidx_r + LW'(1) == ecnt_r);

  // checks
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during emission");
  a_kw_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ekw_r != asl_pkg::NO_KW) |-> (ekind_r < asl_pkg::KIND_LBL))
    else $error("keyword index on non-keyword kind");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(asl_pkg::MAX_TOKEN)) else $error("token length overrun");
  a_toolong_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ekind_r == asl_pkg::KIND_TOO_LONG) |-> stuck_r)
    else $error("too_long without error state");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !ezero_r) |-> (eidx_r < ecnt_r)) else $error("emit index past run");

endmodule
